[hdl/rbc_pkg.sv]
`timescale 1ns / 1ps
// constants, s-box tables and byte/word helpers for the rijndael block cipher
// no dependencies

package rbc_pkg;

  localparam int unsigned MaxBlockWords = 8;
  localparam int unsigned NumRows       = 16;
  localparam int unsigned RowWidth      = MaxBlockWords * 32;

  // size select codes
  localparam logic [1:0] SEL_W4 = 2'd0;
  localparam logic [1:0] SEL_W6 = 2'd1;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_BSIZE = 3'd4;
  localparam logic [2:0] CFG_KSIZE = 3'd5;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] inv_mix_word(logic [31:0] x);
    logic [7:0] a0, a1, a2, a3;
    a0 = x[7:0];
    a1 = x[15:8];
    a2 = x[23:16];
    a3 = x[31:24];
    return {gmul(a0, 4'hb) ^ gmul(a1, 4'hd) ^ gmul(a2, 4'h9) ^ gmul(a3, 4'he),
            gmul(a0, 4'hd) ^ gmul(a1, 4'h9) ^ gmul(a2, 4'he) ^ gmul(a3, 4'hb),
            gmul(a0, 4'h9) ^ gmul(a1, 4'he) ^ gmul(a2, 4'hb) ^ gmul(a3, 4'hd),
            gmul(a0, 4'he) ^ gmul(a1, 4'hb) ^ gmul(a2, 4'hd) ^ gmul(a3, 4'h9)};
  endfunction

  function automatic logic [31:0] fwd_t(logic [7:0] b);
    logic [7:0] s, s2;
    s  = SBOX[b];
    s2 = xt(s);
    return {s ^ s2, s, s, s2};
  endfunction

  function automatic logic [31:0] inv_t(logic [7:0] b);
    logic [7:0] r;
    r = ISBOX[b];
    return {gmul(r, 4'hb), gmul(r, 4'hd), gmul(r, 4'h9), gmul(r, 4'he)};
  endfunction

  function automatic logic [3:0] words_of(logic [1:0] sel);
    return (sel == SEL_W4) ? 4'd4 : ((sel == SEL_W6) ? 4'd6 : 4'd8);
  endfunction

  // source column of a row shift, wrapped into the block width
  function automatic logic [2:0] shift_idx(logic [2:0] j, logic [2:0] off, logic [3:0] nb,
                                           logic dec);
    logic [4:0] s;
    s = dec ? (5'(j) + 5'(nb) - 5'(off)) : (5'(j) + 5'(off));
    if (s >= 5'(nb)) s = s - 5'(nb);
    return s[2:0];
  endfunction

endpackage

[hdl/rijndael_block_cipher.sv]
`timescale 1ns / 1ps
// rijndael block cipher, 128/192/256 bit block and key, round keys held in two row memories
// depends on rbc_pkg

// One block per item, encrypt or decrypt chosen by func_i, nr = 10, 12 or 14 rounds. A new
// item is taken only once the previous block has left the round unit for the output stage:
// one round per cycle through a single shared round unit, fed by the round-key memory of its
// direction, which delivers one whole round key per cycle from a registered read. A result
// left waiting holds the next block in the output stage. After reset or any key or size
// write, the first item waits while the key schedule is rebuilt, one key word per cycle:
// Nb * (nr + 1) words, 44 to 120. Words of the block beyond the configured size are ignored
// and come back as zero.
module rijndael_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [63:0] block_part0_i,
  input  logic [63:0] block_part1_i,
  input  logic [63:0] block_part2_i,
  input  logic [63:0] block_part3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_part0_o,
  output logic [63:0] result_part1_o,
  output logic [63:0] result_part2_o,
  output logic [63:0] result_part3_o
);
  import rbc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXP  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_q;
  logic [63:0] key_q [4];
  logic [1:0]  bsel_q, ksel_q;
  logic        pend_q;

  logic [3:0]  nb, nk, nr;
  logic [2:0]  nkm1, nbm1, c2, c3;

  // key expansion
  logic [3:0]  row_q;
  logic [2:0]  col_q;
  logic [2:0]  kc_q;
  logic        lp_q;
  logic [7:0]  rcon_q;
  logic [31:0] win_q [MaxBlockWords];
  logic [31:0] kw, tw;
  logic        exp_we;
  logic [3:0]  drow;
  logic [31:0] dword;

  // cipher
  logic        dec_q;
  logic [3:0]  rnd_q;
  logic [31:0] a_q [MaxBlockWords];
  logic [31:0] v   [MaxBlockWords];
  logic [3:0]  raddr;
  logic [RowWidth-1:0] erd_q, drd_q, rk;
  logic [RowWidth-1:0] emem [NumRows];
  logic [RowWidth-1:0] dmem [NumRows];

  logic        out_valid_q;
  logic [63:0] res_q [4];

  assign nb   = words_of(bsel_q);
  assign nk   = words_of(ksel_q);
  assign nr   = 4'd6 + ((nb >= nk) ? nb : nk);
  assign nkm1 = 3'(nk - 4'd1);
  assign nbm1 = 3'(nb - 4'd1);
  assign c2   = (nb == 4'd8) ? 3'd3 : 3'd2;
  assign c3   = (nb == 4'd8) ? 3'd4 : 3'd3;

  assign in_ready_o  = (state_q == S_IDLE) && !pend_q;
  assign out_valid_o = out_valid_q;
  assign result_part0_o = res_q[0];
  assign result_part1_o = res_q[1];
  assign result_part2_o = res_q[2];
  assign result_part3_o = res_q[3];

  // next schedule word
  always_comb begin
    kw = key_q[kc_q[2:1]][32*kc_q[0] +: 32];
    tw = win_q[0];
    if (kc_q == 3'd0) begin
      tw = sub_word({win_q[0][7:0], win_q[0][31:8]}) ^ {24'd0, rcon_q};
    end else if (nk == 4'd8 && kc_q == 3'd4) begin
      tw = sub_word(win_q[0]);
    end
    if (!lp_q) kw = win_q[nkm1] ^ tw;
    // first and last round keys go to the inverse schedule unmixed
    dword  = (row_q == 4'd0 || row_q == nr) ? kw : inv_mix_word(kw);
    drow   = nr - row_q;
    exp_we = (state_q == S_EXP);
  end

  // round-key memories
  assign raddr = (state_q == S_RUN) ? rnd_q + 4'd1 : 4'd0;

  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      emem[row_q][32*col_q +: 32] <= kw;
      dmem[drow][32*col_q +: 32]  <= dword;
    end
    erd_q <= emem[raddr];
    drd_q <= dmem[raddr];
  end

  assign rk = dec_q ? drd_q : erd_q;

  // round unit
  always_comb begin
    for (int j = 0; j < MaxBlockWords; j++) begin
      logic [7:0] e0, e1, e2, e3;
      logic [31:0] t0, t1, t2, t3;
      e0 = a_q[j][7:0];
      e1 = a_q[shift_idx(3'(j), 3'd1, nb, dec_q)][15:8];
      e2 = a_q[shift_idx(3'(j), c2, nb, dec_q)][23:16];
      e3 = a_q[shift_idx(3'(j), c3, nb, dec_q)][31:24];
      t0 = dec_q ? inv_t(e0) : fwd_t(e0);
      t1 = dec_q ? inv_t(e1) : fwd_t(e1);
      t2 = dec_q ? inv_t(e2) : fwd_t(e2);
      t3 = dec_q ? inv_t(e3) : fwd_t(e3);
      if (rnd_q == 4'd0) begin
        v[j] = a_q[j];
      end else if (rnd_q == nr) begin
        v[j] = dec_q ? {ISBOX[e3], ISBOX[e2], ISBOX[e1], ISBOX[e0]}
                     : {SBOX[e3], SBOX[e2], SBOX[e1], SBOX[e0]};
      end else begin
        v[j] = t0 ^ {t1[23:0], t1[31:24]} ^ {t2[15:0], t2[31:16]} ^ {t3[7:0], t3[31:8]};
      end
      v[j] = v[j] ^ rk[32*j +: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b1;
      out_valid_q <= 1'b0;
      bsel_q      <= '0;
      ksel_q      <= '0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      row_q  <= '0;
      col_q  <= '0;
      kc_q   <= '0;
      lp_q   <= 1'b1;
      rcon_q <= 8'h01;
      rnd_q  <= '0;
      dec_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
            key_q[cfg_idx_i[1:0]] <= cfg_data_i;
            pend_q <= 1'b1;
          end
          CFG_BSIZE: begin
            bsel_q <= cfg_data_i[1:0];
            pend_q <= 1'b1;
          end
          CFG_KSIZE: begin
            ksel_q <= cfg_data_i[1:0];
            pend_q <= 1'b1;
          end
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && pend_q) begin
            state_q <= S_EXP;
            row_q   <= '0;
            col_q   <= '0;
            kc_q    <= '0;
            lp_q    <= 1'b1;
            rcon_q  <= 8'h01;
          end else if (in_valid_i) begin
            state_q <= S_RUN;
            rnd_q   <= '0;
            dec_q   <= func_i;
          end
        end
        S_EXP: begin
          win_q[0] <= kw;
          for (int i = 1; i < MaxBlockWords; i++) win_q[i] <= win_q[i-1];
          if (!lp_q && kc_q == 3'd0) rcon_q <= xt(rcon_q);
          if (kc_q == nkm1) begin
            kc_q <= '0;
            lp_q <= 1'b0;
          end else begin
            kc_q <= kc_q + 3'd1;
          end
          if (col_q == nbm1) begin
            col_q <= '0;
            row_q <= row_q + 4'd1;
            if (row_q == nr) begin
              // a write in this final step keeps the schedule pending; a write earlier in the rebuild is lost
              if (!cfg_we_i) pend_q <= 1'b0;
              state_q <= S_IDLE;
            end
          end else begin
            col_q <= col_q + 3'd1;
          end
        end
        S_RUN: begin
          rnd_q <= rnd_q + 4'd1;
          if (rnd_q == nr) state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // block state and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_ready_o && in_valid_i) begin
      a_q[0] <= block_part0_i[31:0];
      a_q[1] <= block_part0_i[63:32];
      a_q[2] <= block_part1_i[31:0];
      a_q[3] <= block_part1_i[63:32];
      a_q[4] <= block_part2_i[31:0];
      a_q[5] <= block_part2_i[63:32];
      a_q[6] <= block_part3_i[31:0];
      a_q[7] <= block_part3_i[63:32];
    end else if (state_q == S_RUN) begin
      for (int j = 0; j < MaxBlockWords; j++) a_q[j] <= v[j];
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      for (int p = 0; p < 4; p++) begin
        res_q[p][31:0]  <= (4'(2*p) < nb)     ? a_q[2*p]   : 32'd0;
        res_q[p][63:32] <= (4'(2*p + 1) < nb) ? a_q[2*p+1] : 32'd0;
      end
    end
  end

endmodule
